>>> rtl/gass_pkg.sv
package gass_pkg;

  // grid geometry, cell index = y * MAX_WIDTH + x
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int XW         = 5;
  localparam int YW         = 5;
  localparam int CW         = XW + YW;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int OPEN_DEPTH = 1024;
  localparam int PATH_DEPTH = 63;

  // widths
  localparam int GW    = 26;
  localparam int FW    = 27;
  localparam int HW    = 14;
  localparam int OCW   = 11;
  localparam int OIW   = 10;
  localparam int PCW   = 6;
  localparam int DIMW  = 6;
  localparam int STEPW = 16;
  localparam int CFGIW = 2;
  localparam int SQW   = 27;

  localparam logic [GW-1:0] G_INF = '1;

  // predecessor direction codes
  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_XP   = 3'd1;
  localparam logic [2:0] DIR_YP   = 3'd2;
  localparam logic [2:0] DIR_XM   = 3'd3;
  localparam logic [2:0] DIR_YM   = 3'd4;

  // configuration register indexes
  localparam logic [CFGIW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFGIW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFGIW-1:0] CFG_STEP   = 2'd2;

  typedef struct packed {
    logic [GW-1:0] g;
    logic [2:0]    dir;
    logic          open;
  } cell_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_CLEAR, S_INIT_H, S_INIT_W, S_INIT_WR, S_LOOP,
    S_SC_RD, S_SC_F, S_SC_CMP, S_PICK, S_CUR_RD, S_CUR_WR, S_SH_CHK,
    S_SH_RD, S_SH_WR, S_SH_DONE, S_NB, S_NB_RD, S_NB_CMP, S_NB_H, S_NB_W,
    S_NB_WR, S_NB_NEXT, S_PT_RD, S_PT_CHK, S_EM_INIT, S_EM_RD, S_EM_LD,
    S_EM_OUT, S_NF
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_H_START_S, OP_INIT_WR, OP_SCAN_INIT,
    OP_SC_RD_OL, OP_SC_RD_F, OP_SC_CMP, OP_PICK, OP_CUR_RD, OP_CUR_WR,
    OP_SH_RD, OP_SH_WR, OP_DEC, OP_NB_RD, OP_NB_LATCH, OP_H_START_N,
    OP_NB_WR, OP_NB_NEXT, OP_PT_RD, OP_PT_PUSH, OP_EM_INIT, OP_EM_LD,
    OP_NF_LD
  } op_t;

  typedef struct packed {
    logic bad_query;
    logic clr_last;
    logic h_done;
    logic cnt_zero;
    logic scan_last;
    logic cur_is_goal;
    logic sh_more;
    logic nb_valid;
    logic relax_take;
    logic nb_last;
    logic path_full;
    logic path_end;
    logic path_bad;
    logic out_acc;
    logic out_last;
  } stat_t;

endpackage

>>> rtl/gass_isqrt.sv
module gass_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [gass_pkg::XW-1:0] x,
  input  logic [gass_pkg::YW-1:0] y,
  input  logic [gass_pkg::XW-1:0] gx,
  input  logic [gass_pkg::YW-1:0] gy,
  output logic                   done,
  output logic [gass_pkg::HW-1:0] root
);
  import gass_pkg::*;

  logic [XW-1:0]  dx;
  logic [YW-1:0]  dy;
  logic [2*XW:0]  dsq;
  logic [SQW-1:0] v_r, v_nxt;
  logic [SQW-1:0] r_r, r_nxt;
  logic [SQW-1:0] bit_r;
  logic [SQW:0]   trial;
  logic           busy_r, done_r;

  // squared distance, shifted into Q11.16 before the root so that the root is in Q6.8
  assign dx  = (x > gx) ? x - gx : gx - x;
  assign dy  = (y > gy) ? y - gy : gy - y;
  assign dsq = (2*XW+1)'(dx * dx) + (2*XW+1)'(dy * dy);

  // one digit of the restoring root per cycle
  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  always_comb begin
    if ({1'b0, v_r} >= trial) begin
      v_nxt = v_r - trial[SQW-1:0];
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if ((bit_r >> 2) == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= {dsq[SQW-17:0], 16'b0};
      r_r   <= '0;
      bit_r <= SQW'(1) << (SQW - 1);
    end else if (busy_r) begin
      v_r   <= v_nxt;
      r_r   <= r_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[HW-1:0];

endmodule

>>> rtl/gass_dp.sv
module gass_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gass_pkg::op_t              op,
  output gass_pkg::stat_t            stat,
  input  logic [gass_pkg::XW-1:0]    in_start_x,
  input  logic [gass_pkg::YW-1:0]    in_start_y,
  input  logic [gass_pkg::XW-1:0]    in_goal_x,
  input  logic [gass_pkg::YW-1:0]    in_goal_y,
  input  logic                       cfg_valid,
  input  logic [gass_pkg::CFGIW-1:0] cfg_index,
  input  logic [gass_pkg::STEPW-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gass_pkg::XW-1:0]    out_path_x,
  output logic [gass_pkg::YW-1:0]    out_path_y,
  output logic                       out_found,
  output logic                       out_last
);
  import gass_pkg::*;

  // configuration
  logic [DIMW-1:0]  cfg_w_r, cfg_h_r;
  logic [STEPW-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= DIMW'(MAX_WIDTH);
      cfg_h_r <= DIMW'(MAX_HEIGHT);
      step_r  <= STEPW'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_w_r <= cfg_data[DIMW-1:0];
        CFG_HEIGHT: cfg_h_r <= cfg_data[DIMW-1:0];
        CFG_STEP:   step_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // query registers with clamped grid size
  logic [XW-1:0]   sx_r, gx_r;
  logic [YW-1:0]   sy_r, gy_r;
  logic [DIMW-1:0] w_r, h_r;
  logic [CW-1:0]   s_cell, g_cell;

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      gx_r <= in_goal_x;
      gy_r <= in_goal_y;
      w_r  <= (cfg_w_r == '0) ? DIMW'(1) :
              (cfg_w_r > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH) : cfg_w_r;
      h_r  <= (cfg_h_r == '0) ? DIMW'(1) :
              (cfg_h_r > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT) : cfg_h_r;
    end
  end

  assign s_cell = {sy_r, sx_r};
  assign g_cell = {gy_r, gx_r};

  // search registers
  logic [CW-1:0]  clr_r, cur_r, cell_s_r, pc_r;
  logic [OIW-1:0] i_r, j_r, sel_r;
  logic [OCW-1:0] count_r;
  logic [FW-1:0]  best_f_r;
  logic [GW-1:0]  g_cur_r, tent_r;
  logic           nopen_r;
  logic [1:0]     k_r;
  logic [PCW-1:0] pcount_r, e_r;

  // memories and their registered read words
  cell_t          cell_mem [CELLS];
  logic [FW-1:0]  f_mem    [CELLS];
  logic [CW-1:0]  ol_mem   [OPEN_DEPTH];
  logic [CW-1:0]  stk_mem  [PATH_DEPTH];
  cell_t          cell_q_r;
  logic [FW-1:0]  f_q_r;
  logic [CW-1:0]  ol_q_r, stk_q_r;

  // heuristic unit
  logic            h_start, h_done;
  logic [XW-1:0]   h_x;
  logic [YW-1:0]   h_y;
  logic [HW-1:0]   h_root;

  // neighbor of the current cell for index k
  logic [XW-1:0]   cx;
  logic [YW-1:0]   cy;
  logic [CW-1:0]   n_cell;
  logic [2:0]      n_dir;
  logic            n_ok;

  assign cx = cur_r[XW-1:0];
  assign cy = cur_r[CW-1:XW];

  always_comb begin
    case (k_r)
      2'd0: begin
        n_ok = (cx != '0); n_cell = cur_r - CW'(1); n_dir = DIR_XP;
      end
      2'd1: begin
        n_ok = (cy != '0); n_cell = cur_r - CW'(MAX_WIDTH); n_dir = DIR_YP;
      end
      2'd2: begin
        n_ok = ((DIMW'(cx) + DIMW'(1)) < w_r); n_cell = cur_r + CW'(1);
        n_dir = DIR_XM;
      end
      default: begin
        n_ok = ((DIMW'(cy) + DIMW'(1)) < h_r);
        n_cell = cur_r + CW'(MAX_WIDTH); n_dir = DIR_YM;
      end
    endcase
  end

  assign h_start = (op == OP_H_START_S) || (op == OP_H_START_N);
  assign h_x     = (op == OP_H_START_S) ? sx_r : n_cell[XW-1:0];
  assign h_y     = (op == OP_H_START_S) ? sy_r : n_cell[CW-1:XW];

  gass_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .x     (h_x),
    .y     (h_y),
    .gx    (gx_r),
    .gy    (gy_r),
    .done  (h_done),
    .root  (h_root)
  );

  // tentative cost through the current cell
  logic [GW:0]    tent;
  assign tent = {1'b0, g_cur_r} + (GW+1)'(step_r);

  // next cell on the way back along the predecessor chain
  logic [CW:0]    pc_next;
  logic           d_end;
  always_comb begin
    d_end = 1'b0;
    case (cell_q_r.dir)
      DIR_XP:  pc_next = {1'b0, pc_r} + (CW+1)'(1);
      DIR_YP:  pc_next = {1'b0, pc_r} + (CW+1)'(MAX_WIDTH);
      DIR_XM:  pc_next = {1'b0, pc_r} - (CW+1)'(1);
      DIR_YM:  pc_next = {1'b0, pc_r} - (CW+1)'(MAX_WIDTH);
      default: begin
        pc_next = {1'b0, pc_r};
        d_end   = 1'b1;
      end
    endcase
  end

  // cell store write port
  logic          cell_we;
  logic [CW-1:0] cell_waddr, cell_raddr;
  cell_t         cell_wdata;

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_r;
    cell_wdata = '{g: G_INF, dir: DIR_NONE, open: 1'b0};
    case (op)
      OP_CLEAR: cell_we = 1'b1;
      OP_INIT_WR: begin
        cell_we    = 1'b1;
        cell_waddr = s_cell;
        cell_wdata = '{g: '0, dir: DIR_NONE, open: 1'b1};
      end
      OP_CUR_WR: begin
        cell_we    = 1'b1;
        cell_waddr = cur_r;
        cell_wdata = '{g: cell_q_r.g, dir: cell_q_r.dir, open: 1'b0};
      end
      OP_NB_WR: begin
        cell_we    = 1'b1;
        cell_waddr = n_cell;
        cell_wdata = '{g: tent_r, dir: n_dir, open: 1'b1};
      end
      default: ;
    endcase
  end

  always_comb begin
    case (op)
      OP_CUR_RD: cell_raddr = cur_r;
      OP_NB_RD:  cell_raddr = n_cell;
      default:   cell_raddr = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_q_r <= cell_mem[cell_raddr];
  end

  // estimate store
  logic          f_we;
  logic [CW-1:0] f_waddr;
  logic [FW-1:0] f_wdata;
  assign f_we    = (op == OP_INIT_WR) || (op == OP_NB_WR);
  assign f_waddr = (op == OP_INIT_WR) ? s_cell : n_cell;
  assign f_wdata = (op == OP_INIT_WR) ? FW'(h_root) :
                   ({1'b0, tent_r} + FW'(h_root));

  always_ff @(posedge clk) begin
    if (f_we) f_mem[f_waddr] <= f_wdata;
    f_q_r <= f_mem[ol_q_r];
  end

  // open list
  logic           ol_we, ol_add;
  logic [OIW-1:0] ol_waddr, ol_raddr;
  logic [CW-1:0]  ol_wdata;
  logic [OCW-1:0] j_inc;

  assign j_inc  = {1'b0, j_r} + OCW'(1);
  assign ol_add = (op == OP_NB_WR) && !nopen_r && (count_r < OCW'(OPEN_DEPTH));

  always_comb begin
    ol_we    = 1'b0;
    ol_waddr = j_r;
    ol_wdata = ol_q_r;
    case (op)
      OP_INIT_WR: begin
        ol_we    = 1'b1;
        ol_waddr = '0;
        ol_wdata = s_cell;
      end
      OP_SH_WR: ol_we = 1'b1;
      OP_NB_WR: begin
        ol_we    = ol_add;
        ol_waddr = count_r[OIW-1:0];
        ol_wdata = n_cell;
      end
      default: ;
    endcase
  end

  assign ol_raddr = (op == OP_SH_RD) ? j_inc[OIW-1:0] : i_r;

  always_ff @(posedge clk) begin
    if (ol_we) ol_mem[ol_waddr] <= ol_wdata;
    ol_q_r <= ol_mem[ol_raddr];
  end

  // path stack
  always_ff @(posedge clk) begin
    if (op == OP_PT_PUSH) stk_mem[pcount_r] <= pc_r;
    stk_q_r <= stk_mem[e_r];
  end

  // open count (control state)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      case (op)
        OP_INIT_WR: count_r <= OCW'(1);
        OP_DEC:     count_r <= count_r - OCW'(1);
        OP_NB_WR:   if (ol_add) count_r <= count_r + OCW'(1);
        default:    ;
      endcase
    end
  end

  // search bookkeeping
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD:      clr_r <= '0;
      OP_CLEAR:     clr_r <= clr_r + CW'(1);
      OP_SCAN_INIT: i_r <= '0;
      OP_SC_RD_F:   cell_s_r <= ol_q_r;
      OP_SC_CMP: begin
        if (i_r == '0 || f_q_r < best_f_r) begin
          sel_r    <= i_r;
          best_f_r <= f_q_r;
          cur_r    <= cell_s_r;
        end
        i_r <= i_r + OIW'(1);
      end
      OP_PICK: begin
        j_r      <= sel_r;
        pc_r     <= g_cell;
        pcount_r <= '0;
      end
      OP_CUR_WR:   g_cur_r <= cell_q_r.g;
      OP_SH_WR:    j_r <= j_inc[OIW-1:0];
      OP_DEC:      k_r <= '0;
      OP_NB_LATCH: begin
        nopen_r <= cell_q_r.open;
        tent_r  <= tent[GW-1:0];
      end
      OP_NB_NEXT:  k_r <= k_r + 2'd1;
      OP_PT_PUSH: begin
        pcount_r <= pcount_r + PCW'(1);
        pc_r     <= pc_next[CW-1:0];
      end
      OP_EM_INIT:  e_r <= pcount_r - PCW'(1);
      default: ;
    endcase
    if (out_valid && out_ready) e_r <= e_r - PCW'(1);
  end

  // output register
  logic          out_valid_r, out_found_r, out_last_r;
  logic [XW-1:0] out_x_r;
  logic [YW-1:0] out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EM_LD || op == OP_NF_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EM_LD) begin
      out_x_r     <= stk_q_r[XW-1:0];
      out_y_r     <= stk_q_r[CW-1:XW];
      out_found_r <= 1'b1;
      out_last_r  <= (e_r == '0);
    end else if (op == OP_NF_LD) begin
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_path_x = out_x_r;
  assign out_path_y = out_y_r;
  assign out_found  = out_found_r;
  assign out_last   = out_last_r;

  // status to the controller
  always_comb begin
    stat.bad_query   = (DIMW'(sx_r) >= w_r) || (DIMW'(sy_r) >= h_r) ||
                       (DIMW'(gx_r) >= w_r) || (DIMW'(gy_r) >= h_r);
    stat.clr_last    = (clr_r == CW'(CELLS - 1));
    stat.h_done      = h_done;
    stat.cnt_zero    = (count_r == '0);
    stat.scan_last   = (({1'b0, i_r} + OCW'(1)) >= count_r);
    stat.cur_is_goal = (cur_r == g_cell);
    stat.sh_more     = (j_inc < count_r);
    stat.nb_valid    = n_ok;
    stat.relax_take  = (tent < {1'b0, cell_q_r.g});
    stat.nb_last     = (k_r == 2'd3);
    stat.path_full   = (pcount_r == PCW'(PATH_DEPTH));
    stat.path_end    = d_end;
    stat.path_bad    = pc_next[CW];
    stat.out_acc     = out_valid_r && out_ready;
    stat.out_last    = out_last_r;
  end

endmodule

>>> rtl/gass_ctrl.sv
module gass_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gass_pkg::stat_t stat,
  output gass_pkg::op_t   op
);
  import gass_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = stat.bad_query ? S_NF : S_CLEAR;
      S_CLEAR:   if (stat.clr_last) state_nxt = S_INIT_H;
      S_INIT_H:  state_nxt = S_INIT_W;
      S_INIT_W:  if (stat.h_done) state_nxt = S_INIT_WR;
      S_INIT_WR: state_nxt = S_LOOP;
      S_LOOP:    state_nxt = stat.cnt_zero ? S_NF : S_SC_RD;
      S_SC_RD:   state_nxt = S_SC_F;
      S_SC_F:    state_nxt = S_SC_CMP;
      S_SC_CMP:  state_nxt = stat.scan_last ? S_PICK : S_SC_RD;
      S_PICK:    state_nxt = stat.cur_is_goal ? S_PT_RD : S_CUR_RD;
      S_CUR_RD:  state_nxt = S_CUR_WR;
      S_CUR_WR:  state_nxt = S_SH_CHK;
      S_SH_CHK:  state_nxt = stat.sh_more ? S_SH_RD : S_SH_DONE;
      S_SH_RD:   state_nxt = S_SH_WR;
      S_SH_WR:   state_nxt = S_SH_CHK;
      S_SH_DONE: state_nxt = S_NB;
      S_NB:      state_nxt = stat.nb_valid ? S_NB_RD : S_NB_NEXT;
      S_NB_RD:   state_nxt = S_NB_CMP;
      S_NB_CMP:  state_nxt = stat.relax_take ? S_NB_H : S_NB_NEXT;
      S_NB_H:    state_nxt = S_NB_W;
      S_NB_W:    if (stat.h_done) state_nxt = S_NB_WR;
      S_NB_WR:   state_nxt = S_NB_NEXT;
      S_NB_NEXT: state_nxt = stat.nb_last ? S_LOOP : S_NB;
      S_PT_RD:   state_nxt = stat.path_full ? S_NF : S_PT_CHK;
      S_PT_CHK: begin
        if (stat.path_end)      state_nxt = S_EM_INIT;
        else if (stat.path_bad) state_nxt = S_NF;
        else                    state_nxt = S_PT_RD;
      end
      S_EM_INIT: state_nxt = S_EM_RD;
      S_EM_RD:   state_nxt = S_EM_LD;
      S_EM_LD:   state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (stat.out_acc) state_nxt = stat.out_last ? S_IDLE : S_EM_RD;
      end
      S_NF:      state_nxt = S_EM_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      S_CLEAR:   op = OP_CLEAR;
      S_INIT_H:  op = OP_H_START_S;
      S_INIT_WR: op = OP_INIT_WR;
      S_LOOP:    op = OP_SCAN_INIT;
      S_SC_RD:   op = OP_SC_RD_OL;
      S_SC_F:    op = OP_SC_RD_F;
      S_SC_CMP:  op = OP_SC_CMP;
      S_PICK:    op = OP_PICK;
      S_CUR_RD:  op = OP_CUR_RD;
      S_CUR_WR:  op = OP_CUR_WR;
      S_SH_RD:   op = OP_SH_RD;
      S_SH_WR:   op = OP_SH_WR;
      S_SH_DONE: op = OP_DEC;
      S_NB_RD:   op = OP_NB_RD;
      S_NB_CMP:  op = OP_NB_LATCH;
      S_NB_H:    op = OP_H_START_N;
      S_NB_WR:   op = OP_NB_WR;
      S_NB_NEXT: op = OP_NB_NEXT;
      S_PT_RD:   op = OP_PT_RD;
      S_PT_CHK:  op = OP_PT_PUSH;
      S_EM_INIT: op = OP_EM_INIT;
      S_EM_LD:   op = OP_EM_LD;
      S_NF:      op = OP_NF_LD;
      default:   op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/grid_a_star_path_search.sv
// A* path search over an obstacle-free 4-connected grid.
// Input channel (in_valid/in_ready): one query word holding start and goal
// cells. Output channel (out_valid/out_ready): the path from start to goal,
// one cell per word, out_last on the final word; a single word with
// out_found low reports start or goal off the grid, no path, or a path longer
// than 63 cells. Config channel (cfg_valid/cfg_ready, always ready): index 0
// grid width, 1 grid height, 2 step cost in Q8.8; write only while idle.
// One query at a time: in_ready is high only between queries.
// Per query the block clears all 1024 cells of the g store and seeds the
// start cell, then for each expansion scans the open list for the lowest
// estimate (selection scan), compacts the list behind the chosen entry
// (list compaction) and relaxes up to four neighbors, each relaxation
// waiting on the square-root unit; then it traces the path back from the
// goal and emits it one word at a time.
// Reset (rst_n, synchronous) returns to idle with an empty open list and
// restores the default configuration 32 x 32, step 256.
// When the receiver stalls, the current word holds in the output register
// and the search waits.
module grid_a_star_path_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gass_pkg::XW-1:0]    in_start_x,
  input  logic [gass_pkg::YW-1:0]    in_start_y,
  input  logic [gass_pkg::XW-1:0]    in_goal_x,
  input  logic [gass_pkg::YW-1:0]    in_goal_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gass_pkg::XW-1:0]    out_path_x,
  output logic [gass_pkg::YW-1:0]    out_path_y,
  output logic                       out_found,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gass_pkg::CFGIW-1:0] cfg_index,
  input  logic [gass_pkg::STEPW-1:0] cfg_data
);
  import gass_pkg::*;

  op_t   op;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  gass_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // stores, open list, path stack and output register
  gass_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_goal_x  (in_goal_x),
    .in_goal_y  (in_goal_y),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_path_x (out_path_x),
    .out_path_y (out_path_y),
    .out_found  (out_found),
    .out_last   (out_last)
  );

endmodule
